// ----- hw/rtl/rwap_pkg.sv -----
// rwap_pkg: shared constants and types for the signal-strength window average/peak block.
// Used by rwap_cell, rwap_div and rssi_window_average_peak_core. No dependencies.
`default_nettype none

package rwap_pkg;

    // must stay a power of two: the average is a biased arithmetic shift
    localparam int WINDOW_LEN = 16;
    localparam int SAMPLE_W   = 8;

    // running window sum, signed, wide enough for WINDOW_LEN * -128
    localparam int SUM_W = $clog2(WINDOW_LEN * 128 + 1) + 1;
    // shift that divides the sum by WINDOW_LEN
    localparam int AVG_SHIFT = $clog2(WINDOW_LEN);
    // scan step counter
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [1:0]                 mode_t;

    localparam mode_t MODE_UNUSED = 2'd0;  // no meaning of its own, acts as live
    localparam mode_t MODE_LIVE   = 2'd1;
    localparam mode_t MODE_AVG    = 2'd2;
    localparam mode_t MODE_PEAK   = 2'd3;

endpackage : rwap_pkg

`default_nettype wire

// ----- hw/rtl/rwap_cell.sv -----
// rwap_cell: one window slot; loads its neighbor's sample when the chain shifts.
// Depends on rwap_pkg.
`default_nettype none

module rwap_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             shift_en,
    input  wire rwap_pkg::sample_t d_in,
    output rwap_pkg::sample_t     q_out
);
    import rwap_pkg::*;

    sample_t sample_reg;
    sample_t sample_next;

    assign sample_next = shift_en ? d_in : sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign q_out = sample_reg;

endmodule : rwap_cell

`default_nettype wire

// ----- hw/rtl/rwap_div.sv -----
// rwap_div: signed window sum divided by WINDOW_LEN (a power of two) as a biased
// arithmetic shift, truncated toward zero; quotient registered on start. Depends on rwap_pkg.
`default_nettype none

module rwap_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire rwap_pkg::sum_t    dividend,
    output logic                   done,
    output rwap_pkg::sample_t      quotient
);
    import rwap_pkg::*;

    logic    done_reg, done_next;
    sample_t quot_reg, quot_next;

    sum_t bias;
    sum_t biased;
    sum_t shifted;

    // negative sums get WINDOW_LEN - 1 added so the shift rounds toward zero
    assign bias    = dividend[SUM_W-1] ? sum_t'(WINDOW_LEN - 1) : sum_t'(0);
    assign biased  = dividend + bias;
    assign shifted = biased >>> AVG_SHIFT;

    // quotient magnitude never exceeds 128, so the low bits carry it
    assign done_next = start || done_reg;
    assign quot_next = start ? shifted[SAMPLE_W-1:0] : quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            quot_reg <= '0;
        end else begin
            done_reg <= done_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule : rwap_div

`default_nettype wire

// ----- hw/rtl/rssi_window_average_peak_core.sv -----
// rssi_window_average_peak_core: sliding window of WINDOW_LEN signal-strength samples.
// A new sample is taken only in the idle state, so the core does not accept the next
// sample until the peak scan, which rotates the cell chain once around, and the result load
// are done; the divider registers the average from the sum at the transfer.
// Reset (aresetn low, synchronous): window cells and running sum to zero, mode to live.
// Depends on rwap_pkg, rwap_cell, rwap_div.
`default_nettype none

module rssi_window_average_peak_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write channel (display mode)
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire rwap_pkg::mode_t   cfg_data,
    // sample input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rwap_pkg::sample_t s_rssi_sample,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rwap_pkg::sample_t      m_selected_power,
    output rwap_pkg::sample_t      m_live_power,
    output rwap_pkg::sample_t      m_average_power,
    output rwap_pkg::sample_t      m_peak_power
);
    import rwap_pkg::*;

    localparam int LAST = WINDOW_LEN - 1;

    typedef enum logic [1:0] {
        S_IDLE,  // ready for a sample transfer
        S_SCAN,  // rotating the chain once, peak compare on the tail cell
        S_WAIT   // wait for divider and a free output register
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    mode_t            mode_reg;
    sum_t             sum_reg;
    sum_t             sum_next;
    sample_t          live_reg;
    sample_t          peak_reg;

    logic    m_valid_reg;
    sample_t sel_out_reg, live_out_reg, avg_out_reg, peak_out_reg;

    logic    in_xfer;
    logic    out_free;
    logic    load_out;
    logic    chain_shift;
    sample_t sel_value;

    // cell chain: cell 0 is the newest sample, the tail cell the oldest
    sample_t cell_d [WINDOW_LEN];
    sample_t cell_q [WINDOW_LEN];

    logic    div_done;
    sample_t div_quot;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == S_WAIT) && div_done && out_free;

    // shift on a transfer (new sample in, oldest drops out) and on every scan step
    // (tail wraps to the head, so WINDOW_LEN steps bring the chain back in place)
    assign chain_shift = in_xfer || (state_reg == S_SCAN);
    assign cell_d[0]   = (state_reg == S_SCAN) ? cell_q[LAST] : s_rssi_sample;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
            if (gi > 0) begin : g_link
                assign cell_d[gi] = cell_q[gi-1];
            end
            rwap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (chain_shift),
                .d_in     (cell_d[gi]),
                .q_out    (cell_q[gi])
            );
        end
    endgenerate

    // running sum: add the new sample, drop the one leaving the tail
    assign sum_next = sum_reg + sum_t'(s_rssi_sample) - sum_t'(cell_q[LAST]);

    rwap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_xfer),
        .dividend (sum_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        unique case (mode_reg)
            MODE_AVG:  sel_value = div_quot;
            MODE_PEAK: sel_value = peak_reg;
            default:   sel_value = live_reg;   // live, and the unused code zero
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            mode_reg    <= MODE_LIVE;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            // a new load wins over the drain of the previous result
            priority if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        sum_reg   <= sum_next;
                        live_reg  <= s_rssi_sample;
                        cnt_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cnt_reg == '0 || cell_q[LAST] > peak_reg) begin
                        peak_reg <= cell_q[LAST];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LAST)) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (load_out) begin
                        sel_out_reg  <= sel_value;
                        live_out_reg <= live_reg;
                        avg_out_reg  <= div_quot;
                        peak_out_reg <= peak_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_power = sel_out_reg;
    assign m_live_power     = live_out_reg;
    assign m_average_power  = avg_out_reg;
    assign m_peak_power     = peak_out_reg;

    // a sample transfer always starts a scan
    a_xfer_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == S_SCAN && cnt_reg == '0)
        else $error("scan did not start after sample transfer");

    // the scan ends after exactly one trip around the chain
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN && cnt_reg == CNT_W'(LAST) |=> state_reg == S_WAIT)
        else $error("scan length wrong");

    // a loaded result is visible the next cycle and the block is ready again
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg && state_reg == S_IDLE)
        else $error("result load lost");

    // peak bounds both the live sample and the average
    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> peak_out_reg >= avg_out_reg && peak_out_reg >= live_out_reg)
        else $error("peak below average or live sample");

endmodule : rssi_window_average_peak_core

`default_nettype wire

// ----- bench/tb_rssi_window_average_peak_core.sv -----
// tb_rssi_window_average_peak_core: self-checking bench for the sliding window average/peak core.
// Top module that drives the core, with a scoreboard class inside that predicts every result.
// Depends on rwap_pkg and rssi_window_average_peak_core.
`default_nettype none

module tb_rssi_window_average_peak_core;
    import rwap_pkg::*;

    class window_scoreboard;
        typedef struct packed {
            sample_t sel;
            sample_t live;
            sample_t avg;
            sample_t peak;
        } power_set_t;

        sample_t     win [WINDOW_LEN];
        int unsigned wr_pos;
        mode_t       mode;
        power_set_t  power_q [$];
        int          errors;
        int          checked;

        function new();
            foreach (win[i]) win[i] = '0;
            wr_pos  = 0;
            mode    = MODE_LIVE;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_mode(mode_t m);
            mode = m;
        endfunction

        // one accepted sample: update the window and queue the predicted result
        function void note_sample(sample_t s);
            int         acc;
            sample_t    top;
            power_set_t p;
            win[wr_pos] = s;
            wr_pos = (wr_pos + 1) % WINDOW_LEN;
            acc = 0;
            top = win[0];
            foreach (win[i]) begin
                acc += int'(win[i]);
                if (win[i] > top) top = win[i];
            end
            p.live = s;
            p.avg  = sample_t'(acc / WINDOW_LEN);  // int division truncates toward zero
            p.peak = top;
            case (mode)
                MODE_AVG:  p.sel = p.avg;
                MODE_PEAK: p.sel = p.peak;
                default:   p.sel = p.live;      // mode zero behaves as live
            endcase
            power_q.push_back(p);
        endfunction

        function void compare_field(string label, sample_t want, sample_t got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, label, want, got);
            end
        endfunction

        function void check_result(power_set_t got);
            power_set_t want;
            if (power_q.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected (sel %0d live %0d avg %0d peak %0d)",
                         $time, got.sel, got.live, got.avg, got.peak);
                return;
            end
            want = power_q.pop_front();
            checked++;
            compare_field("selected_power", want.sel,  got.sel);
            compare_field("live_power",     want.live, got.live);
            compare_field("average_power",  want.avg,  got.avg);
            compare_field("peak_power",     want.peak, got.peak);
        endfunction

        function int pending();
            return power_q.size();
        endfunction

        function void flag_leftover();
            if (power_q.size() != 0) begin
                errors++;
                $display("%0t: %0d expected results never arrived", $time, power_q.size());
            end
        endfunction
    endclass

    // generous bound on the run length
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 305;
    localparam int HOLD_AFTER   = 600;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;    // idle wait before the final leftover check

    logic    aclk          = 1'b0;
    logic    aresetn       = 1'b0;
    logic    cfg_valid     = 1'b0;
    logic    cfg_ready;
    mode_t   cfg_data      = '0;
    logic    s_valid       = 1'b0;
    logic    s_ready;
    sample_t s_rssi_sample = '0;
    logic    m_valid;
    logic    m_ready       = 1'b0;
    sample_t m_selected_power;
    sample_t m_live_power;
    sample_t m_average_power;
    sample_t m_peak_power;

    window_scoreboard book = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned samples_sent = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit [3:0]    modes_used = '0;

    // mode per random phase
    mode_t phase_mode [6] = '{MODE_AVG, MODE_LIVE, MODE_PEAK, MODE_UNUSED, MODE_PEAK, MODE_AVG};

    // stimulus shaping state
    int          level = 0;
    int unsigned burst_left = 0;
    sample_t     burst_val = '0;

    rssi_window_average_peak_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rssi_sample    (s_rssi_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_selected_power (m_selected_power),
        .m_live_power     (m_live_power),
        .m_average_power  (m_average_power),
        .m_peak_power     (m_peak_power)
    );

    always #5 aclk = ~aclk;

    // Watchdog. Counts every cycle; a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, book.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. Values read here are the ones that held before the edge,
    // so a transfer is seen exactly when the core saw it. m_ready gets one
    // update per edge: random stall, or the single long hold-off that lets
    // the core fill up and back-pressure the sample channel.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                book.check_result({m_selected_power, m_live_power,
                                   m_average_power, m_peak_power});
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One sample transfer. Called right after an edge; returns at the edge of
    // the transfer with s_valid still high, so the next call can keep it up
    // without a second assignment in the same step.
    task automatic send_sample(input sample_t v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rssi_sample <= v;
        do @(posedge aclk); while (!s_ready);
        book.note_sample(v);
        samples_sent++;
    endtask

    // Drops valid at the edge of the last transfer, then waits for the window
    // to drain. Every sample makes a result, so an empty queue means idle.
    task automatic end_stream();
        s_valid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
    endtask

    // Mode register transfer; only issued while the core is idle.
    task automatic write_mode(input mode_t m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        book.set_mode(m);
        modes_used[m] = 1'b1;
        cfg_valid <= 1'b0;
    endtask

    // Mix of uniform values, the extremes, a slowly drifting level and bursts
    // of one extreme long enough to fill the window (average hits the rails).
    function automatic sample_t pick_sample();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return burst_val;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            burst_left = $urandom_range(24, 16);
            burst_val  = $urandom_range(1) ? 8'sd127 : -8'sd128;
            return burst_val;
        end else if (r < 60) begin
            return sample_t'($urandom_range(255));
        end else if (r < 75) begin
            case ($urandom_range(3))
                0:       return -8'sd128;
                1:       return 8'sd127;
                2:       return -8'sd1;
                default: return 8'sd0;
            endcase
        end else begin
            level += int'($urandom_range(8)) - 4;
            if (level > 127) level = 127;
            if (level < -128) level = -128;
            return sample_t'(level);
        end
    endfunction

    initial begin
        // hold synchronous reset, then release it
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // Reset mode (live). Window still mostly zeros: zeros count in the
        // sum and the peak, and -1 alone averages to 0, not -1.
        send_sample(-8'sd1);
        send_sample(8'sd1);
        send_sample(8'sd127);
        end_stream();

        // Peak mode while the window fills with the most negative value.
        write_mode(MODE_PEAK);
        repeat (13) send_sample(-8'sd128);
        end_stream();

        // Average mode: flush the early entries so the window is all -128,
        // then check truncation toward zero (-1921/16 gives -120).
        write_mode(MODE_AVG);
        repeat (3) send_sample(-8'sd128);
        send_sample(-8'sd1);
        send_sample(8'sd127);
        end_stream();

        // Mode zero has no meaning of its own and must fall back to live.
        write_mode(MODE_UNUSED);
        send_sample(8'sd127);
        send_sample(8'sd0);
        end_stream();

        // --- random part ---
        // Phases 0-1: sender idles 38%, receiver 72%; phases 2-3 swapped;
        // phases 4-5 no idling. Mode changes only between phases.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 38;
                rx_idle_pct = 72;
            end else if (ph < 4) begin
                tx_idle_pct = 72;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_mode(phase_mode[ph]);
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            end_stream();
        end

        // let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge aclk);
        book.flag_leftover();

        $display("covered %0d samples, %0d results checked, modes written 0b%b",
                 samples_sent, book.checked, modes_used);
        $display("stall patterns on both sides plus a %0d-cycle result hold-off, %0d cycles",
                 HOLD_CYCLES, cycle_count);
        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", book.errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
